// File: rtl/cfp_pkg.sv
// Shared types, constants and helpers of the command frame parser.
package cfp_pkg;

  // Frame field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PosW   = 10;
  localparam int unsigned WordW  = 16;
  localparam int unsigned IndexW = 8;

  // Byte position saturation point
  localparam logic [PosW-1:0] PosMax = 10'd1023;

  // Fixed byte positions inside a frame
  localparam logic [PosW-1:0] PosHeader2 = 10'd1;
  localparam logic [PosW-1:0] PosCode    = 10'd2;
  localparam logic [PosW-1:0] PosLength  = 10'd3;
  localparam logic [PosW-1:0] PosBody    = 10'd4;

  // Command codes on the wire
  localparam logic [ByteW-1:0] CodeWalkStop  = 8'h01;
  localparam logic [ByteW-1:0] CodeWalkStart = 8'h02;
  localparam logic [ByteW-1:0] CodeSetJoint  = 8'h05;

  // Register reset values
  localparam logic [ByteW-1:0] HeaderFirstRst  = 8'hFA;
  localparam logic [ByteW-1:0] HeaderSecondRst = 8'hAF;

  // Configuration register map, word address
  localparam int unsigned PaddrW = 3;
  localparam logic RegHeaderFirst  = 1'b0;
  localparam logic RegHeaderSecond = 1'b1;

  typedef enum logic {
    KIND_WORD    = 1'b0,
    KIND_SUMMARY = 1'b1
  } cfp_kind_e;

  typedef enum logic [1:0] {
    CMD_WALK_STOP  = 2'd0,
    CMD_WALK_START = 2'd1,
    CMD_SET_JOINT  = 2'd2,
    CMD_UNKNOWN    = 2'd3
  } cfp_cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_SHORT  = 3'd1,
    ST_BAD_HEADER = 3'd2,
    ST_BAD_CSUM   = 3'd3,
    ST_TRUNCATED  = 3'd4
  } cfp_status_e;

  // Input request: one frame byte
  typedef struct packed {
    logic [ByteW-1:0] frame_byte;
    logic             frame_end;
  } cfp_in_t;

  // Output request: payload word or frame summary
  typedef struct packed {
    cfp_kind_e         item_kind;
    logic [IndexW-1:0] word_index;
    logic [WordW-1:0]  word_value;
    cfp_cmd_e          command_kind;
    cfp_status_e       frame_status;
  } cfp_out_t;

  // Expected header bytes
  typedef struct packed {
    logic [ByteW-1:0] header_first;
    logic [ByteW-1:0] header_second;
  } cfp_cfg_t;

  // Command code to command kind
  function automatic cfp_cmd_e map_command(input logic [ByteW-1:0] code);
    cfp_cmd_e kind;
    unique case (code)
      CodeWalkStop:  kind = CMD_WALK_STOP;
      CodeWalkStart: kind = CMD_WALK_START;
      CodeSetJoint:  kind = CMD_SET_JOINT;
      default:       kind = CMD_UNKNOWN;
    endcase
    return kind;
  endfunction

endpackage

// File: rtl/cfp_regs.sv
// APB-style configuration registers holding the expected header bytes.
module cfp_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cfp_pkg::PaddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output cfp_pkg::cfp_cfg_t             cfg_o
);

  logic [cfp_pkg::ByteW-1:0] hdr_first_q;
  logic [cfp_pkg::ByteW-1:0] hdr_second_q;
  logic                      wr_en;
  logic                      reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= cfp_pkg::HeaderFirstRst;
      hdr_second_q <= cfp_pkg::HeaderSecondRst;
    end else if (wr_en) begin
      unique case (reg_sel)
        cfp_pkg::RegHeaderFirst:  hdr_first_q  <= pwdata[cfp_pkg::ByteW-1:0];
        cfp_pkg::RegHeaderSecond: hdr_second_q <= pwdata[cfp_pkg::ByteW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_sel)
      cfp_pkg::RegHeaderFirst:  prdata = {24'd0, hdr_first_q};
      cfp_pkg::RegHeaderSecond: prdata = {24'd0, hdr_second_q};
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o.header_first  = hdr_first_q;
  assign cfg_o.header_second = hdr_second_q;

endmodule

// File: rtl/cfp_core.sv
// Input register, frame state and per-byte result logic of the parser.
module cfp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfp_pkg::cfp_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cfp_pkg::cfp_in_t  in_req_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output cfp_pkg::cfp_out_t res_o
);

  // Input register
  logic             in_valid_q;
  cfp_pkg::cfp_in_t in_q;

  // Frame state
  logic [cfp_pkg::PosW-1:0]  pos_q, pos_d;
  logic [cfp_pkg::ByteW-1:0] xor_q, xor_d;
  logic                      hdr_q, hdr_d;
  logic [cfp_pkg::ByteW-1:0] code_q, code_d;
  logic [cfp_pkg::ByteW-1:0] words_q, words_d;
  logic [cfp_pkg::ByteW-1:0] hold_q, hold_d;

  logic                      emit;
  logic                      fire;
  logic                      take;
  logic [cfp_pkg::ByteW-1:0] b;
  logic                      last;
  logic [cfp_pkg::ByteW-1:0] sum_code;
  logic [cfp_pkg::ByteW-1:0] sum_len;
  logic                      sum_hdr;
  logic [cfp_pkg::PosW:0]    body_end;
  logic [cfp_pkg::PosW-2:0]  word_idx;
  logic [cfp_pkg::PosW-1:0]  body_off;

  assign b    = in_q.frame_byte;
  assign last = in_q.frame_end;

  // The held byte leaves when it emits nothing or the result stage takes it
  assign fire       = in_valid_q & (res_ready_i | ~emit);
  assign take       = ~in_valid_q | fire;
  assign in_stall_o = ~take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_valid_i) begin
      in_q <= in_req_i;
    end
  end

  // Summary inputs: the final byte may stand in for the code or the length
  assign sum_code = (pos_q == cfp_pkg::PosCode) ? b : code_q;
  assign sum_len  = (pos_q == cfp_pkg::PosLength) ? b : words_q;
  assign sum_hdr  = hdr_q & ((pos_q != cfp_pkg::PosHeader2) | (b == cfg_i.header_second));
  assign body_end = {1'b0, cfp_pkg::PosBody} + {2'b00, sum_len, 1'b0};

  // Payload word position
  assign body_off = pos_q - cfp_pkg::PosBody;
  assign word_idx = body_off[cfp_pkg::PosW-1:1];

  // Result for the held byte
  always_comb begin
    emit                = 1'b0;
    res_o.item_kind     = cfp_pkg::KIND_WORD;
    res_o.word_index    = word_idx[cfp_pkg::IndexW-1:0];
    res_o.word_value    = {hold_q, b};
    res_o.command_kind  = cfp_pkg::map_command(code_q);
    res_o.frame_status  = cfp_pkg::ST_OK;
    if (last) begin
      emit               = 1'b1;
      res_o.item_kind    = cfp_pkg::KIND_SUMMARY;
      res_o.word_index   = '0;
      res_o.word_value   = '0;
      res_o.command_kind = cfp_pkg::map_command(sum_code);
      if (pos_q < cfp_pkg::PosCode) begin
        res_o.frame_status = cfp_pkg::ST_TOO_SHORT;
        res_o.command_kind = cfp_pkg::CMD_UNKNOWN;
      end else if (!sum_hdr) begin
        res_o.frame_status = cfp_pkg::ST_BAD_HEADER;
      end else if ((pos_q > cfp_pkg::PosCode) && (xor_q != b)) begin
        res_o.frame_status = cfp_pkg::ST_BAD_CSUM;
      end else if ((pos_q == cfp_pkg::PosCode) || ({1'b0, pos_q} < body_end)) begin
        res_o.frame_status = cfp_pkg::ST_TRUNCATED;
      end
    end else if ((pos_q >= cfp_pkg::PosBody) && pos_q[0] &&
                 ({1'b0, word_idx} < {2'b00, words_q})) begin
      emit = 1'b1;
    end
  end

  assign res_valid_o = in_valid_q & emit;

  // Next frame state
  always_comb begin
    pos_d   = pos_q;
    xor_d   = xor_q;
    hdr_d   = hdr_q;
    code_d  = code_q;
    words_d = words_q;
    hold_d  = hold_q;
    if (last) begin
      pos_d   = '0;
      xor_d   = '0;
      hdr_d   = 1'b1;
      code_d  = '0;
      words_d = '0;
      hold_d  = '0;
    end else begin
      if (pos_q == '0) begin
        hdr_d = (b == cfg_i.header_first);
      end else if (pos_q == cfp_pkg::PosHeader2) begin
        hdr_d = hdr_q & (b == cfg_i.header_second);
      end else begin
        xor_d = xor_q ^ b;
      end
      if (pos_q == cfp_pkg::PosCode) begin
        code_d = b;
      end else if (pos_q == cfp_pkg::PosLength) begin
        words_d = b;
      end
      if (pos_q != cfp_pkg::PosMax) begin
        pos_d = pos_q + 1'b1;
      end
      if ((pos_q >= cfp_pkg::PosBody) && !pos_q[0]) begin
        hold_d = b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      xor_q   <= '0;
      hdr_q   <= 1'b1;
      code_q  <= '0;
      words_q <= '0;
      hold_q  <= '0;
    end else if (fire) begin
      pos_q   <= pos_d;
      xor_q   <= xor_d;
      hdr_q   <= hdr_d;
      code_q  <= code_d;
      words_q <= words_d;
      hold_q  <= hold_d;
    end
  end

  // A finished frame leaves a clean state behind
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && last |=> pos_q == '0 && xor_q == '0 && hdr_q)
    else $error("frame state not cleared after final byte");

  // Payload words always carry ok status
  a_word_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.item_kind == cfp_pkg::KIND_WORD |->
      res_o.frame_status == cfp_pkg::ST_OK)
    else $error("payload word with non-ok status");

  // A too-short frame never reports a known command
  a_short_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.frame_status == cfp_pkg::ST_TOO_SHORT |->
      res_o.command_kind == cfp_pkg::CMD_UNKNOWN)
    else $error("too-short frame with known command");

  // Position only moves forward inside a frame
  a_pos_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !last |=> pos_q >= $past(pos_q))
    else $error("byte position moved backward");

  // A stalled input byte keeps the frame state unchanged
  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(pos_q) && $stable(xor_q))
    else $error("frame state changed without a processed byte");

endmodule

// File: rtl/cfp_out_stage.sv
// Result register between the parser logic and the output channel.
module cfp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  output logic              res_ready_o,
  input  cfp_pkg::cfp_out_t res_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cfp_pkg::cfp_out_t out_req_o
);

  logic              valid_q;
  cfp_pkg::cfp_out_t data_q;

  // Free when empty or when the held request leaves this cycle
  assign res_ready_o = ~valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_req_o   = data_q;

endmodule

// File: rtl/command_frame_parser_unit.sv
// Top level of the command frame parser: config port, parser core, result register.
//
// Parses header/length/XOR-checksum command frames arriving one byte per
// request, emitting one request per completed big-endian payload word and one
// frame summary (command kind and status) on the byte flagged frame_end.
// Throughput is one byte per clock cycle while the output is not stalled; a
// byte's result reaches the output through the input register and the result
// register around the combinational parser logic. While a result waits under
// stall, bytes that produce no result keep flowing; the input stalls once a
// byte with a result is held behind the waiting one. Header bytes are compared
// against two registers at byte addresses 0 and 4 (reset 0xFA and 0xAF), which
// may only be written while no frame byte is in flight.
module command_frame_parser_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cfp_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // Byte input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  cfp_pkg::cfp_in_t           in_req_i,
  // Result output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output cfp_pkg::cfp_out_t          out_req_o
);

  cfp_pkg::cfp_cfg_t cfg;
  cfp_pkg::cfp_out_t res;
  logic              res_valid;
  logic              res_ready;

  cfp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  cfp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

// File: bench/cfp_frame_checker.sv
// Frame parser checker: watches both request channels and the config port, predicts, compares.
module cfp_frame_checker
  import cfp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration port, observed
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PaddrW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  // Byte channel, observed
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  cfp_in_t             in_req_i,
  // Result channel, observed
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  cfp_out_t            out_req_i,
  // Status toward the testbench top
  output int                  mismatch_count_o,
  output int                  pending_o
);

  // Header bytes the parser compares against
  logic [ByteW-1:0] hdr_first;
  logic [ByteW-1:0] hdr_second;

  // Per-frame parse state
  logic [PosW-1:0]  pos;
  logic [ByteW-1:0] csum;
  logic             hdr_ok;
  logic [ByteW-1:0] code_byte;
  logic [ByteW-1:0] word_count;
  logic [ByteW-1:0] hi_byte;

  // Results still owed by the block, oldest first
  cfp_out_t parsed_items[$];
  int       mismatches;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic cfp_cmd_e command_of(input logic [ByteW-1:0] code);
    case (code)
      CodeWalkStop:  return CMD_WALK_STOP;
      CodeWalkStart: return CMD_WALK_START;
      CodeSetJoint:  return CMD_SET_JOINT;
      default:       return CMD_UNKNOWN;
    endcase
  endfunction

  function automatic void clear_frame();
    pos        = '0;
    csum       = '0;
    hdr_ok     = 1'b1;
    code_byte  = '0;
    word_count = '0;
    hi_byte    = '0;
  endfunction

  // Advance the parse by one byte; returns 1 when the byte completes a result
  function automatic bit parse_byte(input cfp_in_t req, output cfp_out_t res);
    logic [ByteW-1:0] b;
    logic [PosW-1:0]  p;
    logic [ByteW-1:0] code;
    logic [ByteW-1:0] blen;
    logic             hdr;
    cfp_status_e      st;
    int               idx;
    b   = req.frame_byte;
    p   = pos;
    res = '0;
    if (req.frame_end) begin
      // Final byte: summary with status precedence
      code = (p == PosCode) ? b : code_byte;
      blen = (p == PosLength) ? b : word_count;
      hdr  = hdr_ok;
      if (p == PosHeader2) hdr = hdr && (b == hdr_second);
      if (p < PosCode) begin
        st = ST_TOO_SHORT;
      end else if (!hdr) begin
        st = ST_BAD_HEADER;
      end else if (p > PosCode && csum != b) begin
        st = ST_BAD_CSUM;
      end else if (p == PosCode || int'(p) < int'(PosBody) + 2 * int'(blen)) begin
        st = ST_TRUNCATED;
      end else begin
        st = ST_OK;
      end
      res.item_kind    = KIND_SUMMARY;
      res.command_kind = (p < PosCode) ? CMD_UNKNOWN : command_of(code);
      res.frame_status = st;
      clear_frame();
      return 1'b1;
    end
    // Header compare, or checksum accumulation from the code byte on
    if (p == '0) begin
      hdr_ok = (b == hdr_first);
    end else if (p == PosHeader2) begin
      hdr_ok = hdr_ok && (b == hdr_second);
    end else begin
      csum = csum ^ b;
    end
    if (p == PosCode) begin
      code_byte = b;
    end else if (p == PosLength) begin
      word_count = b;
    end
    if (pos < PosMax) pos = pos + 1'b1;
    // Body: high byte held, word emitted on the low byte while inside the body
    if (p >= PosBody) begin
      idx = (int'(p) - int'(PosBody)) >> 1;
      if (!p[0]) begin
        hi_byte = b;
      end else if (idx < int'(word_count)) begin
        res.item_kind    = KIND_WORD;
        res.word_index   = idx[IndexW-1:0];
        res.word_value   = {hi_byte, b};
        res.command_kind = command_of(code_byte);
        res.frame_status = ST_OK;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Observe every channel at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    cfp_out_t want;
    cfp_out_t pred;
    if (!rst_ni) begin
      hdr_first  = HeaderFirstRst;
      hdr_second = HeaderSecondRst;
      clear_frame();
      parsed_items.delete();
      pending_o <= 0;
    end else begin
      // Result request accepted
      if (out_valid_i && !out_stall_i) begin
        if (parsed_items.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", out_req_i));
        end else begin
          want = parsed_items.pop_front();
          if (out_req_i.item_kind !== want.item_kind)
            report_mismatch($sformatf("item_kind got %0d want %0d",
                                      out_req_i.item_kind, want.item_kind));
          if (out_req_i.word_index !== want.word_index)
            report_mismatch($sformatf("word_index got %0d want %0d",
                                      out_req_i.word_index, want.word_index));
          if (out_req_i.word_value !== want.word_value)
            report_mismatch($sformatf("word_value got %04h want %04h",
                                      out_req_i.word_value, want.word_value));
          if (out_req_i.command_kind !== want.command_kind)
            report_mismatch($sformatf("command_kind got %0d want %0d",
                                      out_req_i.command_kind, want.command_kind));
          if (out_req_i.frame_status !== want.frame_status)
            report_mismatch($sformatf("frame_status got %0d want %0d",
                                      out_req_i.frame_status, want.frame_status));
        end
      end
      // Byte request accepted
      if (in_valid_i && !in_stall_i) begin
        if (parse_byte(in_req_i, pred)) parsed_items.push_back(pred);
      end
      // Register write completes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegHeaderFirst) begin
          hdr_first = pwdata[ByteW-1:0];
        end else begin
          hdr_second = pwdata[ByteW-1:0];
        end
      end
      pending_o <= parsed_items.size();
    end
  end

endmodule

// File: bench/tb.sv
// Testbench top for the command frame parser: clock, reset, frame stimulus and verdict.
module tb;
  import cfp_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  cfp_in_t             in_req_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  cfp_out_t            out_req_o;

  int                  mismatch_count;
  int                  pending;

  // Stimulus controls
  bit                  send_idle_on;
  bit                  stall_on;
  int                  stall_left;
  int                  sent_count;
  logic [ByteW-1:0]    cfg_first;
  logic [ByteW-1:0]    cfg_second;
  logic [ByteW-1:0]    frame_q[$];

  command_frame_parser_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  cfp_frame_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_req_i         (in_req_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_req_i        (out_req_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // 4-unit clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mostly short pauses, now and then a long one
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 99) < 25) begin
      out_stall_i <= 1'b1;
      stall_left  <= pick_pause();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Register write: setup phase, access phase, then back to idle
  task automatic write_reg(input logic reg_idx, input logic [ByteW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {24'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_headers(input logic [ByteW-1:0] first, input logic [ByteW-1:0] second);
    write_reg(RegHeaderFirst, first);
    write_reg(RegHeaderSecond, second);
    cfg_first  = first;
    cfg_second = second;
  endtask

  // One byte request; holds until accepted
  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    int gap;
    gap = send_idle_on ? pick_pause() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= '{frame_byte: b, frame_end: last};
    do @(posedge clk_i); while (in_stall_o);
    sent_count++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Stop sending and let every owed result come out, plus the pipeline depth
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (6) @(posedge clk_i);
  endtask

  // Build a frame: mostly well formed with random content, some noise,
  // truncated bodies, extra trailing bytes and broken checksums
  task automatic build_frame(input bit longest);
    int             r;
    int             words;
    int             cut;
    logic [ByteW-1:0] sum;
    frame_q.delete();
    r = longest ? 0 : $urandom_range(0, 99);
    if (r >= 80) begin
      // noise fragment, sometimes behind a good header
      words = $urandom_range(0, 6);
      if (words >= 2 && $urandom_range(0, 1) == 1) begin
        frame_q.push_back(cfg_first);
        frame_q.push_back(cfg_second);
        words -= 2;
      end
      repeat (words) frame_q.push_back(8'($urandom));
      frame_q.push_back(8'($urandom));
      return;
    end
    frame_q.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : cfg_first);
    frame_q.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : cfg_second);
    case ($urandom_range(0, 4))
      0:       frame_q.push_back(CodeWalkStop);
      1:       frame_q.push_back(CodeWalkStart);
      2:       frame_q.push_back(CodeSetJoint);
      default: frame_q.push_back(8'($urandom));
    endcase
    if (longest) begin
      words = 255;
    end else begin
      words = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
    end
    frame_q.push_back(8'(words));
    repeat (2 * words) frame_q.push_back(8'($urandom));
    r = $urandom_range(0, 99);
    if (longest) begin
      // run past the position saturation point
      while (frame_q.size() < 1030) frame_q.push_back(8'($urandom));
    end else if (r < 10) begin
      cut = $urandom_range(1, frame_q.size() - 2);
      repeat (cut) void'(frame_q.pop_back());
    end else if (r < 20) begin
      repeat ($urandom_range(1, 5)) frame_q.push_back(8'($urandom));
    end
    sum = '0;
    for (int i = 2; i < frame_q.size(); i++) sum ^= frame_q[i];
    if (!longest && $urandom_range(0, 9) == 0) sum ^= 8'($urandom_range(1, 255));
    frame_q.push_back(sum);
  endtask

  // Global time limit
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Main stimulus
  initial begin
    logic [ByteW-1:0] phase_first[6];
    logic [ByteW-1:0] phase_second[6];
    int               phase_start;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    in_req_i     = '0;
    send_idle_on = 1'b1;
    stall_on     = 1'b1;
    sent_count   = 0;
    cfg_first    = HeaderFirstRst;
    cfg_second   = HeaderSecondRst;
    phase_first  = '{8'h00, 8'hFF, 8'($urandom), HeaderFirstRst, 8'($urandom), 8'hFF};
    phase_second = '{8'h00, 8'hFF, 8'($urandom), HeaderSecondRst, 8'($urandom), 8'h00};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames at reset headers
    // final byte at position 0, then at position 1: too short
    frame_q = '{8'h00};
    send_frame();
    frame_q = '{HeaderFirstRst, 8'hFF};
    send_frame();
    // three-byte frame: no checksum check at the code position, body truncated
    frame_q = '{HeaderFirstRst, HeaderSecondRst, CodeSetJoint};
    send_frame();
    // bad first header byte
    frame_q = '{8'h00, HeaderSecondRst, CodeWalkStop};
    send_frame();
    // final byte at position 3 is both checksum and a zero body length
    frame_q = '{HeaderFirstRst, HeaderSecondRst, 8'h00, 8'h00};
    send_frame();
    // one payload word, good checksum
    frame_q = '{HeaderFirstRst, HeaderSecondRst, CodeWalkStart, 8'h01, 8'h12, 8'h34, 8'h25};
    send_frame();
    // bad checksum
    frame_q = '{HeaderFirstRst, HeaderSecondRst, CodeWalkStop, 8'h00, 8'hFF};
    send_frame();
    drain();

    // Random phases, each at its own header setting
    for (int ph = 0; ph < 6; ph++) begin
      set_headers(phase_first[ph], phase_second[ph]);
      send_idle_on = (ph % 3 != 1);
      stall_on     = (ph % 3 != 2);
      phase_start  = sent_count;
      if (ph == 3) begin
        build_frame(1'b1);
        send_frame();
      end
      while (sent_count - phase_start < 110 + (ph == 3 ? 1030 : 0)) begin
        build_frame(1'b0);
        send_frame();
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
